/* hdl/encoder_drive_turn_controller_unit_assert.svh */
// assertion macros for the encoder drive and turn controller checker
// depends on: a clk and an active-low rst_n in the scope of use
`ifndef ENCODER_DRIVE_TURN_CONTROLLER_UNIT_ASSERT_SVH
`define ENCODER_DRIVE_TURN_CONTROLLER_UNIT_ASSERT_SVH

// same-cycle implication, off during reset
`define EDTC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define EDTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/edtc_pkg.sv */
// shared types, codes and reset values of the encoder drive and turn controller
// depends on: nothing
package edtc_pkg;

  typedef enum logic [1:0] {
    MODE_DRIVE = 2'd0,
    MODE_TURN  = 2'd1,
    MODE_LEFT  = 2'd2,
    MODE_RIGHT = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    CMD_FORWARD    = 3'd0,
    CMD_FWD_LEFT   = 3'd1,
    CMD_FWD_RIGHT  = 3'd2,
    CMD_TURN_LEFT  = 3'd3,
    CMD_TURN_RIGHT = 3'd4,
    CMD_BRAKE      = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    MV_IDLE  = 2'd0,
    MV_DRIVE = 2'd1,
    MV_TURN  = 2'd2
  } move_t;

  // configuration register indexes
  localparam logic [2:0] REG_SPEED_HIGH     = 3'd0;
  localparam logic [2:0] REG_SPEED_LOW      = 3'd1;
  localparam logic [2:0] REG_SPIN_SPEED     = 3'd2;
  localparam logic [2:0] REG_BRAKE_STRENGTH = 3'd3;
  localparam logic [2:0] REG_TICKS_PER_DEG  = 3'd4;

  // reset values
  localparam logic [7:0]  RST_SPEED_HIGH     = 8'd200;
  localparam logic [7:0]  RST_SPEED_LOW      = 8'd100;
  localparam logic [7:0]  RST_SPIN_SPEED     = 8'd150;
  localparam logic [7:0]  RST_BRAKE_STRENGTH = 8'd255;
  localparam logic [15:0] RST_TICKS_PER_DEG  = 16'd256;

  localparam logic [7:0] TURN_BRAKE = 8'd255;

  typedef struct packed {
    logic [7:0]  speed_high;
    logic [7:0]  speed_low;
    logic [7:0]  spin_speed;
    logic [7:0]  brake_strength;
    logic [15:0] deg_scale;
  } cfg_t;

  typedef struct packed {
    cmd_t       code;
    logic [7:0] value;
    logic       finished;
    logic       last;
  } res_t;

  typedef struct packed {
    res_t       r0;
    res_t       r1;
    logic [1:0] num;
  } res_pair_t;

endpackage

/* hdl/edtc_core.sv */
// move state, wheel counts and command generation for one event per cycle in which fire is high
// depends on: edtc_pkg
module edtc_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic [1:0]          mode,
  input  logic [15:0]         target,
  input  logic                right_dir,
  input  edtc_pkg::cfg_t      cfg,
  output edtc_pkg::res_pair_t pair
);

  edtc_pkg::move_t    state_r, state_nxt;
  logic [15:0]        left_r, left_nxt;
  logic [15:0]        right_r, right_nxt;
  logic [15:0]        goal_r, goal_nxt;
  logic signed [16:0] last_diff_r, last_diff_nxt;

  logic               is_start, is_drive;
  logic [31:0]        prod;
  logic [15:0]        turn_goal, new_goal;
  logic               goal_zero;
  edtc_pkg::cmd_t     start_code;
  logic [7:0]         start_value, start_brake, run_brake;
  logic               left_inc, right_inc;
  logic [15:0]        left_t, right_t;
  logic               hit;
  logic signed [16:0] diff;
  logic               changed;
  logic signed [18:0] corr, base, left_raw, right_raw;

  function automatic logic [7:0] clamp_spd(input logic signed [18:0] x,
                                           input logic [7:0] lo,
                                           input logic [7:0] hi);
    logic signed [18:0] slo, shi;
    slo = signed'({11'b0, lo});
    shi = signed'({11'b0, hi});
    if (x < slo) begin
      return lo;
    end else if (x > shi) begin
      return hi;
    end
    return x[7:0];
  endfunction

  assign is_start = (mode == edtc_pkg::MODE_DRIVE) || (mode == edtc_pkg::MODE_TURN);
  assign is_drive = (mode == edtc_pkg::MODE_DRIVE);

  // turn goal: degrees times q8.8 ticks per degree, saturated to 16 bits
  assign prod      = {16'b0, target} * {16'b0, cfg.deg_scale};
  assign turn_goal = (|prod[31:24]) ? 16'hFFFF : prod[23:8];
  assign new_goal  = is_drive ? target : turn_goal;
  assign goal_zero = (new_goal == 16'd0);

  assign start_code  = is_drive ? edtc_pkg::CMD_FORWARD :
                       (right_dir ? edtc_pkg::CMD_TURN_RIGHT : edtc_pkg::CMD_TURN_LEFT);
  assign start_value = is_drive ? cfg.speed_high : cfg.spin_speed;
  assign start_brake = is_drive ? cfg.brake_strength : edtc_pkg::TURN_BRAKE;
  assign run_brake   = (state_r == edtc_pkg::MV_TURN) ? edtc_pkg::TURN_BRAKE
                                                       : cfg.brake_strength;

  // saturating tick counts
  assign left_inc  = (mode == edtc_pkg::MODE_LEFT) && (left_r != 16'hFFFF);
  assign right_inc = (mode == edtc_pkg::MODE_RIGHT) && (right_r != 16'hFFFF);
  assign left_t    = left_r + {15'b0, left_inc};
  assign right_t   = right_r + {15'b0, right_inc};
  assign hit       = (left_t >= goal_r) || (right_t >= goal_r);

  // steering correction from the raw count difference
  assign diff      = signed'({1'b0, left_t}) - signed'({1'b0, right_t});
  assign changed   = (diff != last_diff_r);
  assign corr      = signed'({diff[16], diff, 1'b0});
  assign base      = signed'({11'b0, cfg.speed_high});
  assign left_raw  = base - corr;
  assign right_raw = base + corr;

  // next state
  always_comb begin
    state_nxt     = state_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    goal_nxt      = goal_r;
    last_diff_nxt = last_diff_r;
    if (fire) begin
      if (is_start) begin
        left_nxt      = 16'd0;
        right_nxt     = 16'd0;
        last_diff_nxt = 17'sd0;
        goal_nxt      = new_goal;
        if (goal_zero) begin
          state_nxt = edtc_pkg::MV_IDLE;
        end else begin
          state_nxt = is_drive ? edtc_pkg::MV_DRIVE : edtc_pkg::MV_TURN;
        end
      end else if (state_r != edtc_pkg::MV_IDLE) begin
        if (hit) begin
          state_nxt     = edtc_pkg::MV_IDLE;
          left_nxt      = 16'd0;
          right_nxt     = 16'd0;
          last_diff_nxt = 17'sd0;
        end else begin
          left_nxt  = left_t;
          right_nxt = right_t;
          if ((state_r == edtc_pkg::MV_DRIVE) && changed) begin
            last_diff_nxt = diff;
          end
        end
      end
    end
  end

  // results of the current event
  always_comb begin
    pair.num = 2'd0;
    pair.r0  = '{code: edtc_pkg::CMD_BRAKE, value: 8'd0, finished: 1'b0, last: 1'b0};
    pair.r1  = '{code: edtc_pkg::CMD_BRAKE, value: 8'd0, finished: 1'b0, last: 1'b0};
    if (is_start) begin
      pair.r0.code  = start_code;
      pair.r0.value = start_value;
      if (goal_zero) begin
        pair.num = 2'd2;
        pair.r1  = '{code: edtc_pkg::CMD_BRAKE, value: start_brake,
                     finished: 1'b1, last: 1'b1};
      end else begin
        pair.num     = 2'd1;
        pair.r0.last = 1'b1;
      end
    end else if (state_r != edtc_pkg::MV_IDLE) begin
      if (hit) begin
        pair.num = 2'd1;
        pair.r0  = '{code: edtc_pkg::CMD_BRAKE, value: run_brake,
                     finished: 1'b1, last: 1'b1};
      end else if ((state_r == edtc_pkg::MV_DRIVE) && changed) begin
        pair.num = 2'd2;
        pair.r0  = '{code: edtc_pkg::CMD_FWD_LEFT,
                     value: clamp_spd(left_raw, cfg.speed_low, cfg.speed_high),
                     finished: 1'b0, last: 1'b0};
        pair.r1  = '{code: edtc_pkg::CMD_FWD_RIGHT,
                     value: clamp_spd(right_raw, cfg.speed_low, cfg.speed_high),
                     finished: 1'b0, last: 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= edtc_pkg::MV_IDLE;
      left_r      <= 16'd0;
      right_r     <= 16'd0;
      goal_r      <= 16'd0;
      last_diff_r <= 17'sd0;
    end else begin
      state_r     <= state_nxt;
      left_r      <= left_nxt;
      right_r     <= right_nxt;
      goal_r      <= goal_nxt;
      last_diff_r <= last_diff_nxt;
    end
  end

endmodule

/* hdl/edtc_out.sv */
// two-entry result buffer that sends one beat per cycle while out_ready is high
// depends on: edtc_pkg
module edtc_out (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  edtc_pkg::res_pair_t pair,
  input  logic                out_ready,
  output logic                space,
  output logic                out_valid,
  output edtc_pkg::res_t      head
);

  edtc_pkg::res_t head_r, head_nxt;
  edtc_pkg::res_t tail_r, tail_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           pop;

  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && out_ready;
  // a new pair may enter once the buffer drains this cycle
  assign space     = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);
  assign head      = head_r;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    if (load) begin
      head_nxt = pair.r0;
      tail_nxt = pair.r1;
      cnt_nxt  = pair.num;
    end else if (pop) begin
      head_nxt = tail_r;
      cnt_nxt  = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

endmodule

/* hdl/encoder_drive_turn_controller_unit.sv */
// top level of the encoder drive and turn controller
// depends on: edtc_pkg, edtc_core, edtc_out
//
// usage
//   in_* beat: one event, in_mode selects start drive, start turn, left tick
//   or right tick; in_target is ticks for a drive and degrees for a turn,
//   in_right_dir picks the turn direction
//   out_* beat: one motor command; an event yields zero, one or two beats and
//   out_last marks the final beat of an event, out_finished a brake that ends
//   the move
//   cfg_*: write speed_high, speed_low, spin_speed, brake_strength and
//   deg_scale by index, only while no event is in flight
// timing
//   an event is registered at the input, evaluated by the core once the result
//   buffer has space, and its beats are then registered in the result buffer;
//   a new event can be taken while the beats of the last one are still sent;
//   the two-entry result buffer is what paces the input
// reset
//   synchronous active-low rst_n: idle, counts and goal cleared, registers at
//   their defaults, no beats pending
// stalls
//   while out_ready is low the buffered beats hold and in_ready drops once the
//   input register is full; no beat is lost or repeated
module encoder_drive_turn_controller_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [15:0] in_target,
  input  logic        in_right_dir,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_command_code,
  output logic [7:0]  out_command_value,
  output logic        out_finished,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // configuration registers
  edtc_pkg::cfg_t      cfg_r, cfg_nxt;

  // input register
  logic                in_vld_r, in_vld_nxt;
  logic [1:0]          mode_r;
  logic [15:0]         target_r;
  logic                right_dir_r;

  logic                space;
  logic                fire;
  logic                in_take;
  edtc_pkg::res_pair_t pair;
  edtc_pkg::res_t      head;

  // event is evaluated when the result buffer can take its beats
  assign fire     = in_vld_r && space;
  assign in_ready = !in_vld_r || fire;
  assign in_take  = in_valid && in_ready;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_take) begin
      in_vld_nxt = 1'b1;
    end else if (fire) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      mode_r      <= in_mode;
      target_r    <= in_target;
      right_dir_r <= in_right_dir;
    end
  end

  // register write decode, indexes past the list are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        edtc_pkg::REG_SPEED_HIGH:     cfg_nxt.speed_high     = cfg_data[7:0];
        edtc_pkg::REG_SPEED_LOW:      cfg_nxt.speed_low      = cfg_data[7:0];
        edtc_pkg::REG_SPIN_SPEED:     cfg_nxt.spin_speed     = cfg_data[7:0];
        edtc_pkg::REG_BRAKE_STRENGTH: cfg_nxt.brake_strength = cfg_data[7:0];
        edtc_pkg::REG_TICKS_PER_DEG:  cfg_nxt.deg_scale      = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed_high     <= edtc_pkg::RST_SPEED_HIGH;
      cfg_r.speed_low      <= edtc_pkg::RST_SPEED_LOW;
      cfg_r.spin_speed     <= edtc_pkg::RST_SPIN_SPEED;
      cfg_r.brake_strength <= edtc_pkg::RST_BRAKE_STRENGTH;
      cfg_r.deg_scale      <= edtc_pkg::RST_TICKS_PER_DEG;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  edtc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .mode      (mode_r),
    .target    (target_r),
    .right_dir (right_dir_r),
    .cfg       (cfg_r),
    .pair      (pair)
  );

  edtc_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .pair      (pair),
    .out_ready (out_ready),
    .space     (space),
    .out_valid (out_valid),
    .head      (head)
  );

  assign out_command_code  = head.code;
  assign out_command_value = head.value;
  assign out_finished      = head.finished;
  assign out_last          = head.last;

endmodule

/* hdl/edtc_checker.sv */
// port-level checks of the result channel, bound to the top level
// depends on: edtc_pkg, encoder_drive_turn_controller_unit_assert.svh
`include "encoder_drive_turn_controller_unit_assert.svh"

module edtc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_command_code,
  input logic [7:0] out_command_value,
  input logic       out_finished,
  input logic       out_last
);

  // a stalled beat holds its payload
  `EDTC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_command_code) && $stable(out_command_value) && $stable(out_finished) && $stable(out_last), "stalled beat changed")

  // a brake always ends the move and nothing else does
  `EDTC_ASSERT_NOW(a_brake_fin, out_valid, (out_command_code == edtc_pkg::CMD_BRAKE) == out_finished, "brake and finished disagree")

  // a finishing beat is the final beat of its event
  `EDTC_ASSERT_NOW(a_fin_last, out_valid && out_finished, out_last, "finished beat not last")

  // the second beat of an event follows right after the first
  `EDTC_ASSERT_NEXT(a_pair_back, out_valid && out_ready && !out_last, out_valid, "gap inside a two-beat event")

endmodule

bind encoder_drive_turn_controller_unit edtc_checker u_edtc_checker (.*);

/* tb/sv/tb_encoder_drive_turn_controller_unit.sv */
`timescale 1ns / 100ps
// self-checking testbench for encoder_drive_turn_controller_unit: event beats in,
// motor command beats predicted by a small scoreboard class and checked in order
// depends on: edtc_pkg and the encoder_drive_turn_controller_unit rtl
module tb_encoder_drive_turn_controller_unit;

  localparam int STEER_GAIN      = 2;
  localparam int ITEMS_PER_PHASE = 180;
  localparam int NUM_PHASES      = 6;
  localparam int LONG_HOLD       = 300;
  localparam int SETTLE_CYCLES   = 8;
  localparam int RUN_LIMIT_NS    = 3_000_000;

  // predicts motor commands from accepted events and checks returned beats
  class command_scoreboard;
    edtc_pkg::cfg_t  regs;
    edtc_pkg::move_t motion;
    logic [15:0]     left_ticks;
    logic [15:0]     right_ticks;
    logic [15:0]     goal;
    int              last_skew;
    edtc_pkg::res_t  queued_cmds[$];
    int              errors;

    function new();
      regs.speed_high     = edtc_pkg::RST_SPEED_HIGH;
      regs.speed_low      = edtc_pkg::RST_SPEED_LOW;
      regs.spin_speed     = edtc_pkg::RST_SPIN_SPEED;
      regs.brake_strength = edtc_pkg::RST_BRAKE_STRENGTH;
      regs.deg_scale      = edtc_pkg::RST_TICKS_PER_DEG;
      motion = edtc_pkg::MV_IDLE;
      goal   = '0;
      errors = 0;
      clear_counts();
    endfunction

    function void clear_counts();
      left_ticks  = '0;
      right_ticks = '0;
      last_skew   = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        edtc_pkg::REG_SPEED_HIGH:     regs.speed_high     = data[7:0];
        edtc_pkg::REG_SPEED_LOW:      regs.speed_low      = data[7:0];
        edtc_pkg::REG_SPIN_SPEED:     regs.spin_speed     = data[7:0];
        edtc_pkg::REG_BRAKE_STRENGTH: regs.brake_strength = data[7:0];
        edtc_pkg::REG_TICKS_PER_DEG:  regs.deg_scale      = data;
        default: ;
      endcase
    endfunction

    function int pending();
      return queued_cmds.size();
    endfunction

    function void push_cmd(edtc_pkg::cmd_t code, logic [7:0] value, logic fin, logic lst);
      edtc_pkg::res_t r;
      r.code     = code;
      r.value    = value;
      r.finished = fin;
      r.last     = lst;
      queued_cmds.push_back(r);
    endfunction

    // low clamp wins when the clamps cross
    function logic [7:0] clamp_speed(int x);
      int lo;
      int hi;
      lo = int'(regs.speed_low);
      hi = int'(regs.speed_high);
      if (x < lo) return regs.speed_low;
      if (x > hi) return regs.speed_high;
      return x[7:0];
    endfunction

    function logic [7:0] brake_value();
      return (motion == edtc_pkg::MV_TURN) ? edtc_pkg::TURN_BRAKE : regs.brake_strength;
    endfunction

    // a tick that lands while idle is ignored by the block
    function void note_event(edtc_pkg::mode_t m, logic [15:0] tgt, logic tr);
      logic [31:0]    scaled;
      edtc_pkg::cmd_t start_cmd;
      logic [7:0]     start_val;
      int             skew;
      if (m == edtc_pkg::MODE_DRIVE || m == edtc_pkg::MODE_TURN) begin
        // a start drops any move in progress without braking
        clear_counts();
        if (m == edtc_pkg::MODE_DRIVE) begin
          motion    = edtc_pkg::MV_DRIVE;
          goal      = tgt;
          start_cmd = edtc_pkg::CMD_FORWARD;
          start_val = regs.speed_high;
        end else begin
          scaled    = (32'(tgt) * 32'(regs.deg_scale)) >> 8;
          motion    = edtc_pkg::MV_TURN;
          goal      = (scaled > 32'h0000_FFFF) ? 16'hFFFF : scaled[15:0];
          start_cmd = tr ? edtc_pkg::CMD_TURN_RIGHT : edtc_pkg::CMD_TURN_LEFT;
          start_val = regs.spin_speed;
        end
        if (goal == 16'd0) begin
          push_cmd(start_cmd, start_val, 1'b0, 1'b0);
          push_cmd(edtc_pkg::CMD_BRAKE, brake_value(), 1'b1, 1'b1);
          motion = edtc_pkg::MV_IDLE;
        end else begin
          push_cmd(start_cmd, start_val, 1'b0, 1'b1);
        end
        return;
      end
      if (motion == edtc_pkg::MV_IDLE) return;
      if (m == edtc_pkg::MODE_LEFT) begin
        if (left_ticks != 16'hFFFF) left_ticks++;
      end else if (right_ticks != 16'hFFFF) begin
        right_ticks++;
      end
      if (left_ticks >= goal || right_ticks >= goal) begin
        push_cmd(edtc_pkg::CMD_BRAKE, brake_value(), 1'b1, 1'b1);
        motion = edtc_pkg::MV_IDLE;
        clear_counts();
      end else if (motion == edtc_pkg::MV_DRIVE) begin
        skew = int'(left_ticks) - int'(right_ticks);
        if (skew != last_skew) begin
          last_skew = skew;
          push_cmd(edtc_pkg::CMD_FWD_LEFT,
                   clamp_speed(int'(regs.speed_high) - STEER_GAIN * skew), 1'b0, 1'b0);
          push_cmd(edtc_pkg::CMD_FWD_RIGHT,
                   clamp_speed(int'(regs.speed_high) + STEER_GAIN * skew), 1'b0, 1'b1);
        end
      end
    endfunction

    task report_mismatch(string what, int got, int want);
      errors++;
      $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    task check_beat(logic [2:0] code, logic [7:0] value, logic fin, logic lst);
      edtc_pkg::res_t want;
      if (queued_cmds.size() == 0) begin
        report_mismatch("beat with nothing expected, code", code, 0);
        return;
      end
      want = queued_cmds.pop_front();
      if (code !== want.code)      report_mismatch("command_code", code, want.code);
      if (value !== want.value)    report_mismatch("command_value", value, want.value);
      if (fin !== want.finished)   report_mismatch("finished", fin, want.finished);
      if (lst !== want.last)       report_mismatch("last", lst, want.last);
    endtask
  endclass

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic [1:0]  in_mode      = '0;
  logic [15:0] in_target    = '0;
  logic        in_right_dir = 1'b0;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic [2:0]  out_command_code;
  logic [7:0]  out_command_value;
  logic        out_finished;
  logic        out_last;
  logic        cfg_we       = 1'b0;
  logic [2:0]  cfg_index    = '0;
  logic [15:0] cfg_data     = '0;

  command_scoreboard sb = new();

  // idle odds in percent for each side, set per phase
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // bumped by the stimulus to ask the receiver for one long hold-off
  int hold_requests = 0;
  // accepted events of every kind
  int live_items    = 0;

  encoder_drive_turn_controller_unit i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_target         (in_target),
    .in_right_dir      (in_right_dir),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_command_code  (out_command_code),
    .out_command_value (out_command_value),
    .out_finished      (out_finished),
    .out_last          (out_last),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // inputs move on the falling edge, every beat is sampled on the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready)
      sb.check_beat(out_command_code, out_command_value, out_finished, out_last);
  end

  // result side: random stalls, plus long hold-offs counted here so the
  // input register and result buffer fill and in_ready has to drop
  initial begin : receiver
    int holds_served;
    int hold_left;
    holds_served = 0;
    hold_left    = 0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && holds_served < hold_requests) begin
        holds_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // one event beat; entered and left on a falling edge, valid stays up
  // after acceptance so back-to-back beats need no gap
  task automatic send_event(edtc_pkg::mode_t m, logic [15:0] tgt, logic tr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_mode      = m;
    in_target    = tgt;
    in_right_dir = tr;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_event(m, tgt, tr);
    live_items++;
    @(negedge clk);
  endtask

  // stop offering and wait for every predicted command, then let a tick
  // that makes no command clear the pipe too
  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic program_reg(logic [2:0] idx, logic [15:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin : stimulus
    edtc_pkg::mode_t m;
    logic [15:0]     tgt;
    logic [15:0]     sh, sl, ts, bs, tpd;
    int              r;
    int              n;
    int              left_pct;
    int              max_deg;
    int              phase_end;
    int              phase_mid;
    bit              paused;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part at reset settings, no idling
    // ticks while idle are dropped
    send_event(edtc_pkg::MODE_LEFT, 16'h0000, 1'b0);
    send_event(edtc_pkg::MODE_RIGHT, 16'hFFFF, 1'b1);
    // zero goals: start command then an immediate brake
    send_event(edtc_pkg::MODE_DRIVE, 16'd0, 1'b0);
    send_event(edtc_pkg::MODE_TURN, 16'd0, 1'b0);
    send_event(edtc_pkg::MODE_TURN, 16'd0, 1'b1);
    // short drive: skew goes +1, 0, +1, then the left wheel hits the goal
    send_event(edtc_pkg::MODE_DRIVE, 16'd3, 1'b0);
    send_event(edtc_pkg::MODE_LEFT, 16'd0, 1'b0);
    send_event(edtc_pkg::MODE_RIGHT, 16'd0, 1'b0);
    send_event(edtc_pkg::MODE_LEFT, 16'd0, 1'b0);
    send_event(edtc_pkg::MODE_LEFT, 16'd0, 1'b0);
    // two-degree right turn, silent ticks until the right wheel reaches it
    send_event(edtc_pkg::MODE_TURN, 16'd2, 1'b1);
    send_event(edtc_pkg::MODE_LEFT, 16'd0, 1'b0);
    send_event(edtc_pkg::MODE_RIGHT, 16'd0, 1'b0);
    send_event(edtc_pkg::MODE_RIGHT, 16'd0, 1'b0);
    // starts on top of moves that are still running
    send_event(edtc_pkg::MODE_DRIVE, 16'hFFFF, 1'b1);
    send_event(edtc_pkg::MODE_LEFT, 16'h5555, 1'b1);
    send_event(edtc_pkg::MODE_TURN, 16'hFFFF, 1'b0);
    send_event(edtc_pkg::MODE_RIGHT, 16'hAAAA, 1'b0);
    send_event(edtc_pkg::MODE_DRIVE, 16'hAAAA, 1'b0);
    send_event(edtc_pkg::MODE_DRIVE, 16'h5555, 1'b1);
    send_event(edtc_pkg::MODE_TURN, 16'd1, 1'b0);
    send_event(edtc_pkg::MODE_RIGHT, 16'd0, 1'b1);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      // sender idles less than the receiver, then the reverse, then neither
      send_idle_pct = (p < 2) ? 37 : (p < 4) ? 65 : 0;
      recv_idle_pct = (p < 2) ? 65 : (p < 4) ? 37 : 0;
      sh  = 16'($urandom_range(65535));
      sl  = 16'($urandom_range(65535));
      ts  = 16'($urandom_range(65535));
      bs  = 16'($urandom_range(65535));
      tpd = 16'($urandom_range(16, 2048));
      case (p)
        0: begin
          // full speeds, zero low clamp, largest ticks per degree
          sh = 16'h00FF; sl = 16'hFF00; ts = 16'h00FF; bs = 16'h5500; tpd = 16'hFFFF;
        end
        1: begin
          // crossed clamps and turns that always end at once
          sh = 16'hFF00; sl = 16'h00FF; ts = 16'hAA00; bs = 16'h00FF; tpd = 16'h0000;
        end
        2: tpd = 16'h0001;
        default: ;
      endcase
      program_reg(edtc_pkg::REG_SPEED_HIGH, sh);
      program_reg(edtc_pkg::REG_SPEED_LOW, sl);
      program_reg(edtc_pkg::REG_SPIN_SPEED, ts);
      program_reg(edtc_pkg::REG_BRAKE_STRENGTH, bs);
      program_reg(edtc_pkg::REG_TICKS_PER_DEG, tpd);

      // keep most turn goals at 24 ticks or under so turns can finish
      max_deg   = (sb.regs.deg_scale == 0) ? 65535
                : (24 * 256) / int'(sb.regs.deg_scale);
      phase_end = live_items + ITEMS_PER_PHASE;
      phase_mid = live_items + ITEMS_PER_PHASE / 2;
      paused    = 1'b0;

      // biggest turn: goal saturates when ticks per degree is large
      send_event(edtc_pkg::MODE_TURN, 16'hFFFF, 1'($urandom));
      hold_requests++;

      while (live_items < phase_end) begin
        if (!paused && live_items >= phase_mid) begin
          drain();
          paused = 1'b1;
        end
        r = $urandom_range(99);
        if (r < 12) begin
          // noise: any event with any payload
          send_event(edtc_pkg::mode_t'($urandom_range(3)), 16'($urandom), 1'($urandom));
        end else begin
          // a start followed by a burst of ticks with a random wheel bias;
          // short bursts abandon the move, long ones overrun it into idle
          if (r < 55) begin
            m   = edtc_pkg::MODE_DRIVE;
            tgt = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(24));
          end else begin
            m   = edtc_pkg::MODE_TURN;
            tgt = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(max_deg));
          end
          send_event(m, tgt, 1'($urandom));
          n        = $urandom_range(30);
          left_pct = $urandom_range(100);
          repeat (n)
            send_event(($urandom_range(99) < left_pct) ? edtc_pkg::MODE_LEFT
                                                       : edtc_pkg::MODE_RIGHT,
                       16'($urandom), 1'($urandom));
        end
      end
    end

    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("FAILURE");
    $finish;
  end

endmodule
